// File: src/bac_pkg.sv
// ----------------------------------------------------------------------------
// bac_pkg
// Shared types, codes and defaults for the bump allocator with record table.
// ----------------------------------------------------------------------------
package bac_pkg;

  localparam int unsigned ARENA_BYTES_DEF  = 1048576;
  localparam int unsigned RECORD_SLOTS_DEF = 64;

  localparam int PTR_W   = 20;
  localparam int SIZE_W  = 21;
  localparam int STAMP_W = 16;

  // Request operation codes
  localparam logic [1:0] CMD_ALLOC  = 2'd0;
  localparam logic [1:0] CMD_RESIZE = 2'd1;
  localparam logic [1:0] CMD_FREE   = 2'd2;

  // Result status codes
  localparam logic [1:0] STS_OK        = 2'd0;
  localparam logic [1:0] STS_EXHAUSTED = 2'd1;
  localparam logic [1:0] STS_TABLE_FULL = 2'd2;
  localparam logic [1:0] STS_NOT_FOUND = 2'd3;

  typedef struct packed {
    logic [1:0]        cmd;
    logic              pointer_null;
    logic [PTR_W-1:0]  pointer_offset;
    logic [SIZE_W-1:0] request_size;
  } req_t;

  typedef struct packed {
    logic              result_null;
    logic [PTR_W-1:0]  result_offset;
    logic [1:0]        status;
    logic              copy_needed;
    logic [PTR_W-1:0]  copy_source;
    logic [SIZE_W-1:0] copy_length;
  } rsp_t;

  typedef struct packed {
    logic               valid;
    logic [PTR_W-1:0]   address;
    logic [SIZE_W-1:0]  length;
    logic [STAMP_W-1:0] stamp;
  } record_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic req_ready;
    logic req_load;
    logic clear_wr;
    logic idx_clr;
    logic idx_inc;
    logic rd_en;
    logic commit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic idx_last;
    logic out_free;
  } ctrl_sts_t;

endpackage

// File: src/bac_chan_if.sv
// ----------------------------------------------------------------------------
// bac_chan_if
// Valid/ready channel carrying one payload beat.
// ----------------------------------------------------------------------------
interface bac_chan_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: src/bac_ctrl.sv
// ----------------------------------------------------------------------------
// bac_ctrl
// Sequencer: table clear after reset, accept, slot scan, commit of the result.
// ----------------------------------------------------------------------------
module bac_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  input  bac_pkg::ctrl_sts_t sts,
  output bac_pkg::ctrl_cmd_t cmd
);

  bac_pkg::state_t state;
  bac_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bac_pkg::S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      bac_pkg::S_CLEAR: begin
        if (sts.idx_last) state_next = bac_pkg::S_IDLE;
      end
      bac_pkg::S_IDLE: begin
        if (req_valid) state_next = bac_pkg::S_SCAN;
      end
      bac_pkg::S_SCAN: begin
        if (sts.idx_last) state_next = bac_pkg::S_DRAIN;
      end
      bac_pkg::S_DRAIN: begin
        state_next = bac_pkg::S_FINISH;
      end
      bac_pkg::S_FINISH: begin
        if (sts.out_free) state_next = bac_pkg::S_IDLE;
      end
      default: begin
        state_next = bac_pkg::S_CLEAR;
      end
    endcase
  end

  always_comb begin
    cmd = '0;
    case (state)
      bac_pkg::S_CLEAR: begin
        cmd.clear_wr = 1'b1;
        cmd.idx_inc  = ~sts.idx_last;
        cmd.idx_clr  = sts.idx_last;
      end
      bac_pkg::S_IDLE: begin
        cmd.req_ready = 1'b1;
        cmd.req_load  = req_valid;
        cmd.idx_clr   = req_valid;
      end
      bac_pkg::S_SCAN: begin
        cmd.rd_en   = 1'b1;
        cmd.idx_inc = 1'b1;
      end
      bac_pkg::S_DRAIN: begin
        cmd = '0;
      end
      bac_pkg::S_FINISH: begin
        // hold the result until the output register can take it
        cmd.commit = sts.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

// File: src/bac_datapath.sv
// ----------------------------------------------------------------------------
// bac_datapath
// Record memory, scan trackers, bump offset, stamp counter and result register.
// ----------------------------------------------------------------------------
module bac_datapath #(
  parameter int unsigned ARENA_BYTES  = bac_pkg::ARENA_BYTES_DEF,
  parameter int unsigned RECORD_SLOTS = bac_pkg::RECORD_SLOTS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  bac_pkg::ctrl_cmd_t cmd,
  output bac_pkg::ctrl_sts_t sts,
  input  bac_pkg::req_t      req_data,
  output logic               rsp_valid,
  input  logic               rsp_ready,
  output bac_pkg::rsp_t      rsp_data
);

  localparam int IW = (RECORD_SLOTS > 1) ? $clog2(RECORD_SLOTS) : 1;
  localparam int BW = $clog2(ARENA_BYTES + 1);
  localparam int CW = (BW > bac_pkg::SIZE_W) ? BW : bac_pkg::SIZE_W;
  localparam logic [BW-1:0] ARENA_TOP = BW'(ARENA_BYTES);
  localparam logic [IW-1:0] IDX_LAST  = IW'(RECORD_SLOTS - 1);

  bac_pkg::record_t mem [RECORD_SLOTS];

  bac_pkg::req_t    req_q;
  logic [IW-1:0]    idx;
  logic             rd_valid;
  logic [IW-1:0]    rd_idx;
  bac_pkg::record_t rd_data;

  logic                        free_found;
  logic [IW-1:0]               free_idx;
  logic                        match_found;
  logic [IW-1:0]               match_idx;
  logic [bac_pkg::STAMP_W-1:0] best_age;
  logic [bac_pkg::SIZE_W-1:0]  best_len;
  logic [bac_pkg::STAMP_W-1:0] best_stamp;

  logic [BW-1:0]               bump;
  logic [bac_pkg::STAMP_W-1:0] counter;

  logic [bac_pkg::STAMP_W-1:0] age;
  logic                        hit;
  logic                        fits;
  logic                        do_alloc;

  logic                        fin_wr;
  logic [IW-1:0]               fin_idx;
  bac_pkg::record_t            fin_word;
  logic                        fin_advance;
  bac_pkg::rsp_t               fin_rsp;

  logic                        wr_en;
  logic [IW-1:0]               wr_idx;
  bac_pkg::record_t            wr_word;

  assign sts.idx_last = (idx == IDX_LAST);
  assign sts.out_free = ~rsp_valid | rsp_ready;

  assign age = counter - rd_data.stamp;
  assign hit = rd_data.valid && (rd_data.address == req_q.pointer_offset);
  assign fits = (bump < ARENA_TOP) &&
                (CW'(req_q.request_size) <= CW'(ARENA_TOP - bump));
  assign do_alloc = (req_q.cmd == bac_pkg::CMD_ALLOC) ||
                    ((req_q.cmd == bac_pkg::CMD_RESIZE) && req_q.pointer_null);

  // Outcome of the request once the scan is complete
  always_comb begin
    fin_wr                  = 1'b0;
    fin_idx                 = match_idx;
    fin_word.valid          = 1'b1;
    fin_word.address        = bac_pkg::PTR_W'(bump);
    fin_word.length         = req_q.request_size;
    fin_word.stamp          = counter;
    fin_advance             = 1'b0;
    fin_rsp                 = '0;
    fin_rsp.result_null     = 1'b1;
    fin_rsp.status          = bac_pkg::STS_OK;
    if (do_alloc) begin
      if (!fits) begin
        fin_rsp.status = bac_pkg::STS_EXHAUSTED;
      end else if (!free_found) begin
        fin_rsp.status = bac_pkg::STS_TABLE_FULL;
      end else begin
        fin_wr                = 1'b1;
        fin_idx               = free_idx;
        fin_advance           = 1'b1;
        fin_rsp.result_null   = 1'b0;
        fin_rsp.result_offset = bac_pkg::PTR_W'(bump);
      end
    end else begin
      case (req_q.cmd)
        bac_pkg::CMD_RESIZE: begin
          if (!match_found) begin
            fin_rsp.status = bac_pkg::STS_NOT_FOUND;
          end else if (best_len >= req_q.request_size) begin
            // shrink in place, keep address and stamp
            fin_wr                = 1'b1;
            fin_word.address      = req_q.pointer_offset;
            fin_word.stamp        = best_stamp;
            fin_rsp.result_null   = 1'b0;
            fin_rsp.result_offset = req_q.pointer_offset;
          end else if (!fits) begin
            fin_rsp.status = bac_pkg::STS_EXHAUSTED;
          end else begin
            fin_wr                = 1'b1;
            fin_advance           = 1'b1;
            fin_rsp.result_null   = 1'b0;
            fin_rsp.result_offset = bac_pkg::PTR_W'(bump);
            if (best_len != '0) begin
              fin_rsp.copy_needed = 1'b1;
              fin_rsp.copy_source = req_q.pointer_offset;
              fin_rsp.copy_length = best_len;
            end
          end
        end
        bac_pkg::CMD_FREE: begin
          if (!req_q.pointer_null) begin
            if (!match_found) begin
              fin_rsp.status = bac_pkg::STS_NOT_FOUND;
            end else begin
              fin_wr         = 1'b1;
              fin_word.valid = 1'b0;
            end
          end
        end
        default: begin
          fin_wr = 1'b0;
        end
      endcase
    end
  end

  assign wr_en   = cmd.clear_wr | (cmd.commit & fin_wr);
  assign wr_idx  = cmd.clear_wr ? idx : fin_idx;
  assign wr_word = cmd.clear_wr ? '0 : fin_word;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_word;
    end
    if (cmd.rd_en) begin
      rd_data <= mem[idx];
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      idx         <= '0;
      rd_valid    <= 1'b0;
      free_found  <= 1'b0;
      match_found <= 1'b0;
      bump        <= '0;
      counter     <= '0;
      rsp_valid   <= 1'b0;
    end else begin
      if (cmd.idx_clr) begin
        idx <= '0;
      end else if (cmd.idx_inc) begin
        idx <= idx + 1'b1;
      end
      rd_valid <= cmd.rd_en;
      if (cmd.req_load) begin
        free_found  <= 1'b0;
        match_found <= 1'b0;
      end else if (rd_valid) begin
        if (!rd_data.valid) free_found <= 1'b1;
        if (hit) match_found <= 1'b1;
      end
      if (cmd.commit && fin_advance) begin
        bump    <= bump + BW'(req_q.request_size);
        counter <= counter + 1'b1;
      end
      if (cmd.commit) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.req_load) begin
      req_q <= req_data;
    end
    if (cmd.rd_en) begin
      rd_idx <= idx;
    end
    if (rd_valid) begin
      if (!rd_data.valid && !free_found) begin
        free_idx <= rd_idx;
      end
      // newest record wins; ascending scan keeps the lowest slot on a tie
      if (hit && (!match_found || (age < best_age))) begin
        match_idx  <= rd_idx;
        best_age   <= age;
        best_len   <= rd_data.length;
        best_stamp <= rd_data.stamp;
      end
    end
    if (cmd.commit) begin
      rsp_data <= fin_rsp;
    end
  end

endmodule

// File: src/bump_allocator_with_record_table.sv
// ----------------------------------------------------------------------------
// bump_allocator_with_record_table
// Bump-pointer allocator with a scanned table of live allocation records.
// ----------------------------------------------------------------------------
//   channel  direction  beat contents
//   req      in         cmd, pointer_null, pointer_offset, request_size
//   rsp      out        result_null, result_offset, status, copy_*
//
// A request is accepted, then each slot of the record memory is read in turn
// through its single read port, the registered read data is drained and the
// update is committed; the next request is accepted only after that commit.
// After reset a clearing pass invalidates every slot, and req.ready stays
// low meanwhile.
// A result waiting in the output register stalls the commit of the next one.
// ----------------------------------------------------------------------------
module bump_allocator_with_record_table #(
  parameter int unsigned ARENA_BYTES  = bac_pkg::ARENA_BYTES_DEF,
  parameter int unsigned RECORD_SLOTS = bac_pkg::RECORD_SLOTS_DEF
) (
  input logic       clk,
  input logic       rst,
  bac_chan_if.sink   req,
  bac_chan_if.source rsp
);

  bac_pkg::ctrl_cmd_t ctrl_cmd;
  bac_pkg::ctrl_sts_t ctrl_sts;

  assign req.ready = ctrl_cmd.req_ready;

  bac_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .sts       (ctrl_sts),
    .cmd       (ctrl_cmd)
  );

  bac_datapath #(
    .ARENA_BYTES  (ARENA_BYTES),
    .RECORD_SLOTS (RECORD_SLOTS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (ctrl_cmd),
    .sts       (ctrl_sts),
    .req_data  (req.data),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .rsp_data  (rsp.data)
  );

endmodule

// File: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the bump allocator with record table. Requests are
// driven on the req channel, and each accepted beat is run through an
// allocation ledger that keeps its own bump pointer and record table to
// forecast the response. Responses are checked field by field, in order.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import bac_pkg::*;

  localparam int unsigned ARENA = ARENA_BYTES_DEF;
  localparam int unsigned SLOTS = RECORD_SLOTS_DEF;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  // Expected behaviour of the allocator, plus the queue of forecast responses
  class alloc_ledger;
    int unsigned        bump = 0;
    logic [STAMP_W-1:0] stamp_ctr = '0;
    bit                 rec_live[SLOTS];
    logic [PTR_W-1:0]   rec_addr[SLOTS];
    int unsigned        rec_len[SLOTS];
    logic [STAMP_W-1:0] rec_stamp[SLOTS];
    logic [PTR_W-1:0]   handed_out[$];
    rsp_t               pending_results[$];
    int                 failures = 0;

    function bit fits(int unsigned size);
      if (bump >= ARENA) return 1'b0;
      return size <= ARENA - bump;
    endfunction

    // Newest record at an address: smallest wrapped age, lowest slot on a tie
    function int newest_slot(logic [PTR_W-1:0] addr);
      int best = -1;
      logic [STAMP_W-1:0] best_age = '0;
      logic [STAMP_W-1:0] age;
      for (int i = 0; i < SLOTS; i++) begin
        if (rec_live[i] && rec_addr[i] == addr) begin
          age = stamp_ctr - rec_stamp[i];
          if (best < 0 || age < best_age) begin
            best = i;
            best_age = age;
          end
        end
      end
      return best;
    endfunction

    function void take(int slot, int unsigned size);
      rec_live[slot]  = 1'b1;
      rec_addr[slot]  = PTR_W'(bump);
      rec_len[slot]   = size;
      rec_stamp[slot] = stamp_ctr;
      handed_out.push_back(PTR_W'(bump));
      if (handed_out.size() > 256) void'(handed_out.pop_front());
      stamp_ctr++;
      bump += size;
    endfunction

    function rsp_t allocate(int unsigned size);
      rsp_t res = '0;
      int slot = -1;
      res.result_null = 1'b1;
      if (!fits(size)) begin
        res.status = STS_EXHAUSTED;
        return res;
      end
      for (int i = 0; i < SLOTS; i++)
        if (!rec_live[i] && slot < 0) slot = i;
      if (slot < 0) begin
        res.status = STS_TABLE_FULL;
        return res;
      end
      res.result_null   = 1'b0;
      res.result_offset = PTR_W'(bump);
      take(slot, size);
      return res;
    endfunction

    function rsp_t predict(req_t r);
      rsp_t res = '0;
      int slot;
      int unsigned size = 32'(r.request_size);
      res.result_null = 1'b1;
      if (r.cmd == CMD_ALLOC || (r.cmd == CMD_RESIZE && r.pointer_null))
        return allocate(size);
      if (r.cmd == CMD_RESIZE) begin
        slot = newest_slot(r.pointer_offset);
        if (slot < 0) begin
          res.status = STS_NOT_FOUND;
          return res;
        end
        if (rec_len[slot] >= size) begin
          rec_len[slot]     = size;
          res.result_null   = 1'b0;
          res.result_offset = r.pointer_offset;
          return res;
        end
        if (!fits(size)) begin
          res.status = STS_EXHAUSTED;
          return res;
        end
        // Move the old contents unless the old block was empty
        if (rec_len[slot] != 0) begin
          res.copy_needed = 1'b1;
          res.copy_source = rec_addr[slot];
          res.copy_length = SIZE_W'(rec_len[slot]);
        end
        res.result_null   = 1'b0;
        res.result_offset = PTR_W'(bump);
        take(slot, size);
        return res;
      end
      if (r.cmd == CMD_FREE && !r.pointer_null) begin
        slot = newest_slot(r.pointer_offset);
        if (slot < 0) res.status = STS_NOT_FOUND;
        else rec_live[slot] = 1'b0;
      end
      return res;
    endfunction

    function void note_request(req_t r);
      pending_results.push_back(predict(r));
    endfunction

    function void compare(string field, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        if (failures < 10)
          $display("%0t: %s mismatch: expected %h, got %h", $realtime, field, want, got);
        failures++;
      end
    endfunction

    function void check_result(rsp_t got);
      rsp_t want;
      if (pending_results.size() == 0) begin
        if (failures < 10)
          $display("%0t: response beat with nothing outstanding: %h", $realtime, got);
        failures++;
        return;
      end
      want = pending_results.pop_front();
      compare("result_null", 32'(want.result_null), 32'(got.result_null));
      compare("result_offset", 32'(want.result_offset), 32'(got.result_offset));
      compare("status", 32'(want.status), 32'(got.status));
      compare("copy_needed", 32'(want.copy_needed), 32'(got.copy_needed));
      compare("copy_source", 32'(want.copy_source), 32'(got.copy_source));
      compare("copy_length", 32'(want.copy_length), 32'(got.copy_length));
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;
  bit   steady = 1'b0;

  alloc_ledger book = new;

  bac_chan_if #(.payload_t(req_t)) req_ch ();
  bac_chan_if #(.payload_t(rsp_t)) rsp_ch ();

  bump_allocator_with_record_table #(
    .ARENA_BYTES  (ARENA),
    .RECORD_SLOTS (SLOTS)
  ) DUT (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic req_t make_req(logic [1:0] cmd, logic pnull, logic [PTR_W-1:0] off,
                                    int unsigned size);
    req_t r;
    r.cmd            = cmd;
    r.pointer_null   = pnull;
    r.pointer_offset = off;
    r.request_size   = SIZE_W'(size);
    return r;
  endfunction

  // Mostly live addresses, some stale ones, the rest anywhere
  function automatic logic [PTR_W-1:0] pick_pointer();
    int live_slots[$];
    int p = $urandom_range(0, 99);
    for (int i = 0; i < SLOTS; i++)
      if (book.rec_live[i]) live_slots.push_back(i);
    if (p < 75 && live_slots.size() > 0)
      return book.rec_addr[live_slots[$urandom_range(0, live_slots.size() - 1)]];
    if (p < 88 && book.handed_out.size() > 0)
      return book.handed_out[$urandom_range(0, book.handed_out.size() - 1)];
    return PTR_W'($urandom_range(0, 20'hFFFFF));
  endfunction

  // Keep most sizes small so the arena lasts; now and then ask for too much
  function automatic int unsigned random_size();
    int unsigned left = (book.bump >= ARENA) ? 0 : ARENA - book.bump;
    int p = $urandom_range(0, 99);
    if (p < 8) return 0;
    if (p < 75) return $urandom_range(1, 64);
    if (p < 94) return $urandom_range(65, 4096);
    if (left == ARENA) return 64;
    return $urandom_range(left + 1, ARENA);
  endfunction

  task automatic drive_req(input req_t r);
    int gap;
    if (!steady && $urandom_range(0, 99) < 20) begin
      req_ch.valid <= 1'b0;
      gap = $urandom_range(1, 90);
      repeat (gap) @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.data  <= r;
    do @(posedge clk); while (!req_ch.ready);
    book.note_request(r);
  endtask

  task automatic run_phase(input int alloc_w, input int resize_w, input int count);
    req_t r;
    int done = 0;
    int p;
    while (done < count) begin
      r = '0;
      if ($urandom_range(0, 99) < 6) begin
        r.cmd            = CMD_UNUSED;
        r.pointer_null   = 1'($urandom_range(0, 1));
        r.pointer_offset = PTR_W'($urandom_range(0, 20'hFFFFF));
        r.request_size   = SIZE_W'($urandom_range(0, ARENA));
      end else begin
        p = $urandom_range(0, 99);
        r.pointer_offset = pick_pointer();
        r.request_size   = SIZE_W'(random_size());
        r.pointer_null   = ($urandom_range(0, 9) == 0);
        if (p < alloc_w) r.cmd = CMD_ALLOC;
        else if (p < alloc_w + resize_w) r.cmd = CMD_RESIZE;
        else r.cmd = CMD_FREE;
        done++;
      end
      drive_req(r);
    end
  endtask

  // Response side: check each beat, stall at random
  initial begin
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && rsp_ch.valid && rsp_ch.ready) book.check_result(rsp_ch.data);
      rsp_ch.ready <= !rst && (steady || $urandom_range(0, 99) >= 20);
    end
  end

  initial begin
    rst          <= 1'b1;
    req_ch.valid <= 1'b0;
    req_ch.data  <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Two records at offset 0; the newer one must match
    drive_req(make_req(CMD_ALLOC, 1'b0, 20'hFFFFF, 0));
    drive_req(make_req(CMD_ALLOC, 1'b1, 20'h00000, 16));
    drive_req(make_req(CMD_RESIZE, 1'b0, 20'h00000, 8));
    drive_req(make_req(CMD_RESIZE, 1'b0, 20'h00000, 40));
    // Grow of the empty record: no copy
    drive_req(make_req(CMD_RESIZE, 1'b0, 20'h00000, 4));
    drive_req(make_req(CMD_RESIZE, 1'b1, 20'h12345, 32));
    drive_req(make_req(CMD_ALLOC, 1'b0, 20'h00000, ARENA));
    drive_req(make_req(CMD_RESIZE, 1'b0, 20'h00010, ARENA));
    drive_req(make_req(CMD_RESIZE, 1'b0, 20'hFFFFF, 5));
    drive_req(make_req(CMD_FREE, 1'b1, 20'h00010, 0));
    drive_req(make_req(CMD_FREE, 1'b0, 20'hABCDE, 0));
    drive_req(make_req(CMD_FREE, 1'b0, 20'h00010, 0));
    drive_req(make_req(CMD_FREE, 1'b0, 20'h00010, 0));
    drive_req(make_req(CMD_UNUSED, 1'b1, 20'hFFFFF, ARENA));
    drive_req(make_req(CMD_UNUSED, 1'b0, 20'h00000, 0));
    drive_req(make_req(CMD_RESIZE, 1'b0, 20'h00038, 4));
    // Free drops the newest of two records at one address
    drive_req(make_req(CMD_ALLOC, 1'b0, 20'h00000, 0));
    drive_req(make_req(CMD_ALLOC, 1'b0, 20'h00000, 8));
    drive_req(make_req(CMD_FREE, 1'b0, 20'h0005C, 0));
    drive_req(make_req(CMD_RESIZE, 1'b0, 20'h0005C, 1));

    run_phase(60, 25, 220);
    steady = 1'b1;
    run_phase(40, 35, 180);
    steady = 1'b0;
    run_phase(20, 30, 200);

    // Use up the arena exactly, then everything that needs space must fail
    drive_req(make_req(CMD_ALLOC, 1'b0, 20'h00000, ARENA - book.bump));
    drive_req(make_req(CMD_ALLOC, 1'b0, 20'h00000, 0));
    drive_req(make_req(CMD_RESIZE, 1'b1, 20'h00000, 0));
    drive_req(make_req(CMD_RESIZE, 1'b0, pick_pointer(), ARENA));
    drive_req(make_req(CMD_FREE, 1'b0, pick_pointer(), 0));
    req_ch.valid <= 1'b0;

    while (book.pending_results.size() != 0) @(posedge clk);
    repeat (SLOTS + 10) @(posedge clk);
    if (book.failures == 0 && book.pending_results.size() == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

  // Hang guard: 20 ms, far beyond the slowest legal run
  initial begin
    #20_000_000;
    $display("tb_top: FAIL");
    $finish;
  end

endmodule
